// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while the synchronous active-low reset is released
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== src/sbe_pkg.sv =====
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types and constants of the stack bytecode evaluator.
// ----------------------------------------------------------------------------
package sbe_pkg;

    // Bytecode opcodes
    localparam logic [7:0] BC_ADD  = 8'd1;
    localparam logic [7:0] BC_MUL  = 8'd2;
    localparam logic [7:0] BC_PUSH = 8'd3;

    // Queue depths (powers of two)
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    // Stack operation handed from the parser to the executor
    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_MUL,
        OP_PUSH
    } t_op;

    // Parser phase
    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_LENGTH,
        PH_DATA
    } t_phase;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK,
        ST_UNDER,
        ST_OVER,
        ST_TRUNC
    } t_status;

    // Decoded command: one stack op, optionally closing the program
    typedef struct packed {
        t_op         op;
        logic [31:0] value;
        logic        last;
        logic        trunc;
    } t_cmd;

    // Program result
    typedef struct packed {
        logic [31:0] value;
        t_status     status;
    } t_result;

endpackage

// ===== src/sbe_fifo.sv =====
// ----------------------------------------------------------------------------
// sbe_fifo
// Small synchronous FIFO built from registers; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module sbe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wptr;
    logic [AW:0]      r_rptr;
    logic             w_wr;
    logic             w_rd;

    // Extra pointer bit tells full from empty
    assign o_empty = (r_wptr == r_rptr);
    assign o_full  = (r_wptr[AW] != r_rptr[AW]) && (r_wptr[AW-1:0] == r_rptr[AW-1:0]);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr[AW-1:0]];

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + (AW+1)'(1);
            end
            if (w_rd) begin
                r_rptr <= r_rptr + (AW+1)'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr[AW-1:0]] <= i_data;
        end
    end

endmodule

// ===== src/sbe_front.sv =====
// ----------------------------------------------------------------------------
// sbe_front
// Byte parser: tracks opcode / length / data phases, assembles immediates
// and turns each byte into at most one stack command.
// ----------------------------------------------------------------------------
module sbe_front
    import sbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_code_byte,
    input  logic       i_last_byte,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_rem, n_rem;
    logic [31:0] r_acc, n_acc;
    t_phase      w_phase_step;
    logic [7:0]  w_rem_dec;
    logic [31:0] w_acc_shift;

    assign w_rem_dec   = r_rem - 8'd1;
    assign w_acc_shift = {r_acc[23:0], i_code_byte};

    // Next state
    always_comb begin
        w_phase_step = r_phase;
        n_rem        = r_rem;
        n_acc        = r_acc;
        case (r_phase)
            PH_OPCODE: begin
                if (i_code_byte == BC_PUSH) begin
                    w_phase_step = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (i_code_byte == 8'd0) begin
                    w_phase_step = PH_OPCODE;
                end else begin
                    n_rem        = i_code_byte;
                    n_acc        = '0;
                    w_phase_step = PH_DATA;
                end
            end
            PH_DATA: begin
                n_acc = w_acc_shift;
                n_rem = w_rem_dec;
                if (w_rem_dec == 8'd0) begin
                    n_acc        = '0;
                    w_phase_step = PH_OPCODE;
                end
            end
            default: begin
                w_phase_step = PH_OPCODE;
            end
        endcase
        n_phase = w_phase_step;
        // program end drops any partial immediate
        if (i_last_byte) begin
            n_phase = PH_OPCODE;
            n_rem   = '0;
            n_acc   = '0;
        end
    end

    // Command decode
    always_comb begin
        o_cmd.op    = OP_NONE;
        o_cmd.value = '0;
        case (r_phase)
            PH_OPCODE: begin
                if (i_code_byte == BC_ADD) begin
                    o_cmd.op = OP_ADD;
                end else if (i_code_byte == BC_MUL) begin
                    o_cmd.op = OP_MUL;
                end
            end
            PH_LENGTH: begin
                if (i_code_byte == 8'd0) begin
                    o_cmd.op = OP_PUSH;
                end
            end
            PH_DATA: begin
                if (w_rem_dec == 8'd0) begin
                    o_cmd.op    = OP_PUSH;
                    o_cmd.value = w_acc_shift;
                end
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
        o_cmd.last  = i_last_byte;
        o_cmd.trunc = i_last_byte && (w_phase_step != PH_OPCODE);
        o_cmd_valid = i_accept && ((o_cmd.op != OP_NONE) || i_last_byte);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPCODE;
            r_rem   <= '0;
            r_acc   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_acc   <= n_acc;
        end
    end

endmodule

// ===== src/sbe_back.sv =====
// ----------------------------------------------------------------------------
// sbe_back
// Stack executor: top two entries cached in registers, the rest in a
// single-port-write, registered-read memory; one command per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module sbe_back
    import sbe_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);

    // Entries below the top two
    logic [31:0]    r_mem [STACK_DEPTH];
    logic [31:0]    r_rd;

    logic [SPW-1:0] r_sp;
    logic [31:0]    r_top;
    logic [31:0]    r_sec;
    logic [31:0]    r_below;
    logic           r_use_rd;
    t_status        r_err;

    logic           w_fire;
    logic [SPW-1:0] w_sp;
    logic [31:0]    w_top;
    logic [31:0]    w_sec;
    t_status        w_err;
    logic           w_we;
    logic           w_pushed_down;
    logic           w_popped;
    logic [AW-1:0]  w_waddr;
    logic [AW-1:0]  w_raddr;
    logic [31:0]    w_below;
    logic [31:0]    w_sum;
    logic [31:0]    w_prod;

    assign w_fire    = i_cmd_valid && !i_res_full;
    assign o_cmd_pop = w_fire;
    assign w_below   = r_use_rd ? r_rd : r_below;
    assign w_sum     = r_top + r_sec;
    assign w_prod    = r_top * r_sec;
    assign w_waddr   = AW'(r_sp - SPW'(2));
    assign w_raddr   = AW'(w_sp - SPW'(3));

    // Stack update and program end
    always_comb begin
        w_sp          = r_sp;
        w_top         = r_top;
        w_sec         = r_sec;
        w_err         = r_err;
        w_we          = 1'b0;
        w_pushed_down = 1'b0;
        w_popped      = 1'b0;
        o_res.value   = '0;
        o_res.status  = ST_OK;
        if (w_fire) begin
            case (i_cmd.op)
                OP_PUSH: begin
                    if (r_sp < SPW'(STACK_DEPTH)) begin
                        w_top = i_cmd.value;
                        w_sec = r_top;
                        w_sp  = r_sp + SPW'(1);
                        if (r_sp >= SPW'(2)) begin
                            w_we          = 1'b1;
                            w_pushed_down = 1'b1;
                        end
                    end else if (w_err == ST_OK) begin
                        w_err = ST_OVER;
                    end
                end
                OP_ADD, OP_MUL: begin
                    if (r_sp >= SPW'(2)) begin
                        w_top    = (i_cmd.op == OP_ADD) ? w_sum : w_prod;
                        w_sec    = w_below;
                        w_sp     = r_sp - SPW'(1);
                        w_popped = 1'b1;
                    end else if (w_err == ST_OK) begin
                        w_err = ST_UNDER;
                    end
                end
                default: begin
                    w_sp = r_sp;
                end
            endcase
            // final pop
            if (i_cmd.last) begin
                if (i_cmd.trunc && (w_err == ST_OK)) begin
                    w_err = ST_TRUNC;
                end
                if (w_sp == '0) begin
                    if (w_err == ST_OK) begin
                        w_err = ST_UNDER;
                    end
                end else begin
                    o_res.value = w_top;
                end
                o_res.status = w_err;
            end
        end
        o_res_push = w_fire && i_cmd.last;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_err    <= ST_OK;
            r_use_rd <= 1'b0;
        end else if (w_fire) begin
            r_sp  <= i_cmd.last ? '0 : w_sp;
            r_err <= i_cmd.last ? ST_OK : w_err;
            if (w_pushed_down) begin
                r_use_rd <= 1'b0;
            end else if (w_popped) begin
                r_use_rd <= 1'b1;
            end
        end
    end

    // Cached top entries
    always_ff @(posedge i_clk) begin
        r_top <= w_top;
        r_sec <= w_sec;
        if (w_pushed_down) begin
            r_below <= r_sec;
        end
    end

    // Stack memory: spill on push, prefetch the next entry down every cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= r_sec;
        end
        r_rd <= r_mem[w_raddr];
    end

endmodule

// ===== src/stack_bytecode_evaluator.sv =====
// ----------------------------------------------------------------------------
// stack_bytecode_evaluator
// Evaluates straight-line stack bytecode fed one byte per item.
// ----------------------------------------------------------------------------
// Input channel: one program byte (i_code_byte) per item, i_last_byte marks
//   the final byte. Accepted on a clock edge with push high and full low.
// Result channel: one item per program (o_result_value, o_status) shown
//   while empty is low, taken on a clock edge with pop high.
// Throughput: one byte per cycle while the result queue has room. The parser
//   classifies a byte in the cycle it is accepted; the executor retires one
//   command per cycle under the same condition, with the top two stack
//   entries in registers and the next entry prefetched from the stack
//   memory's registered read port.
// Result path: the last byte enters the drained command queue at its edge;
//   the executor's result is then registered into the result queue.
// Stall: when the result queue fills, the executor halts, the 4-entry
//   command queue absorbs further bytes, then full rises.
// Reset: synchronous, active low; clears parser, stack pointer, error
//   state and both queues. The stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
module stack_bytecode_evaluator
    import sbe_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_code_byte,
    input  logic               i_last_byte,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_result_value,
    output logic [1:0]         o_status
);

    logic    w_accept;
    logic    w_cmd_valid;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    logic    w_cmd_empty;
    logic    w_cmd_pop;
    logic    w_res_full;
    logic    w_res_push;
    t_result w_res_in;
    t_result w_res_out;

    assign w_accept = push && !full;

    // Parser
    sbe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_code_byte (i_code_byte),
        .i_last_byte (i_last_byte),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd_in)
    );

    // Command queue between parser and executor
    sbe_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_data  (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    // Executor
    sbe_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!w_cmd_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    // Result queue
    sbe_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_result_value = $signed(w_res_out.value);
    assign o_status       = w_res_out.status;

endmodule

// ===== src/sbe_check.sv =====
// ----------------------------------------------------------------------------
// sbe_check
// Port-level checks of the stack bytecode evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbe_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic [7:0]         i_code_byte,
    input logic               i_last_byte,
    input logic               empty,
    input logic               pop,
    input logic signed [31:0] o_result_value,
    input logic [1:0]         o_status
);

    // Reset empties both queues
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (empty && !full), "queues not cleared by reset")

    // Input queue fills only through accepted items
    `ASSERT_RUN(a_full_needs_push, i_clk, i_rst_n, (!full && !push) |=> !full, "full rose without an accepted item")

    // A waiting result is not withdrawn
    `ASSERT_RUN(a_result_stays, i_clk, i_rst_n, (!empty && !pop) |=> !empty, "result dropped before pop")

    // A waiting result holds its value
    `ASSERT_RUN(a_result_holds, i_clk, i_rst_n, (!empty && !pop) |=> ($stable(o_result_value) && $stable(o_status)), "result changed while stalled")

endmodule

bind stack_bytecode_evaluator sbe_check u_check (.*);

// ===== tb/sv/stack_bytecode_evaluator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bytecode_evaluator_test
// Self-checking bench for the stack bytecode evaluator. A short table of
// programs covers the corner cases, then random programs (clean, cut short,
// noise and one deep stack) run against a behavioral evaluator, with random
// bursts on the byte side and random stalls on the result side.
// ----------------------------------------------------------------------------
module stack_bytecode_evaluator_test;
    import sbe_pkg::*;

    localparam int DEPTH       = 256;
    localparam int TOTAL_ITEMS = 1440;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 10;

    // One row of the directed table; typed rows carry the result by hand
    typedef struct packed {
        logic [7:0]  code;
        logic        last;
        logic        typed;
        logic [31:0] value;
        t_status     status;
    } t_row;

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
    } t_outcome;

    typedef enum {PROG_CLEAN, PROG_CUT, PROG_NOISE, PROG_DEEP} t_prog_kind;

    localparam t_row NO_TAG = '0;

    localparam t_row DIRECTED_ROWS [25] = '{
        '{8'h00, 1'b1, 1'b1, 32'h0000_0000, ST_UNDER},   // empty program
        '{8'h03, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h00, 1'b1, 1'b1, 32'h0000_0000, ST_OK},      // zero-length push
        '{8'h03, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h04, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, ST_OK},      // all-ones immediate
        '{8'h03, 1'b1, 1'b1, 32'h0000_0000, ST_TRUNC},   // ends on push opcode
        '{8'h01, 1'b0, 1'b0, 32'h0, ST_OK},              // add on empty stack
        '{8'h03, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h01, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h7F, 1'b1, 1'b1, 32'h0000_007F, ST_UNDER},   // sticky, top still out
        '{8'h03, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h04, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h80, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h00, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h00, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h00, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h03, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h01, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'h02, 1'b0, 1'b0, 32'h0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 32'h0, ST_OK},              // unknown opcode, skipped
        '{8'h02, 1'b1, 1'b1, 32'h0000_0000, ST_OK}       // product wraps to zero
    };

    // DUT ports
    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    logic               full;
    logic [7:0]         i_code_byte = 8'h00;
    logic               i_last_byte = 1'b0;
    logic               empty;
    logic               pop         = 1'b0;
    logic signed [31:0] o_result_value;
    logic [1:0]         o_status;

    // Evaluator state
    logic [31:0] eval_stack [DEPTH];
    int          eval_sp    = 0;
    t_phase      eval_phase = PH_OPCODE;
    int          eval_left  = 0;
    logic [31:0] eval_accum = '0;
    t_status     eval_err   = ST_OK;

    // Bench bookkeeping
    t_outcome   expected_results [$];
    t_row       pending_tags [$];
    logic [7:0] prog_bytes [$];
    int         items_sent  = 0;
    int         burst_left  = 0;
    int         mismatches  = 0;
    int         cycle_count = 0;
    int         pop_mode    = 0;
    int         pop_hold    = 0;

    stack_bytecode_evaluator #(
        .STACK_DEPTH(DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_code_byte    (i_code_byte),
        .i_last_byte    (i_last_byte),
        .empty          (empty),
        .pop            (pop),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // First error of the program sticks
    function automatic void record_error(input t_status code);
        if (eval_err == ST_OK) eval_err = code;
    endfunction

    function automatic void stack_push(input logic [31:0] v);
        if (eval_sp < DEPTH) begin
            eval_stack[eval_sp] = v;
            eval_sp++;
        end else begin
            record_error(ST_OVER);
        end
    endfunction

    // Consume one byte; returns 1 with the program result on the last byte
    function automatic bit evaluate_byte(input logic [7:0] b, input bit lst,
                                         output logic [31:0] v, output t_status s);
        logic [31:0] top;
        logic [31:0] nxt;
        v = '0;
        s = ST_OK;
        case (eval_phase)
            PH_LENGTH: begin
                if (b == 8'h00) begin
                    stack_push('0);
                    eval_phase = PH_OPCODE;
                end else begin
                    eval_left  = int'(b);
                    eval_accum = '0;
                    eval_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                eval_accum = {eval_accum[23:0], b};
                eval_left--;
                if (eval_left == 0) begin
                    stack_push(eval_accum);
                    eval_accum = '0;
                    eval_phase = PH_OPCODE;
                end
            end
            default: begin
                if (b == BC_ADD || b == BC_MUL) begin
                    if (eval_sp < 2) begin
                        record_error(ST_UNDER);
                    end else begin
                        top = eval_stack[eval_sp - 1];
                        nxt = eval_stack[eval_sp - 2];
                        eval_sp--;
                        eval_stack[eval_sp - 1] = (b == BC_ADD) ? top + nxt : top * nxt;
                    end
                end else if (b == BC_PUSH) begin
                    eval_phase = PH_LENGTH;
                end
            end
        endcase
        if (!lst) return 1'b0;

        // Program end: pop the top and clear for the next program
        if (eval_phase != PH_OPCODE) record_error(ST_TRUNC);
        if (eval_sp == 0) begin
            record_error(ST_UNDER);
        end else begin
            eval_sp--;
            v = eval_stack[eval_sp];
        end
        s          = eval_err;
        eval_sp    = 0;
        eval_phase = PH_OPCODE;
        eval_left  = 0;
        eval_accum = '0;
        eval_err   = ST_OK;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h (cycle %0d)",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    // Present one item, honoring the burst/gap pattern, and wait for acceptance
    task automatic send_item(input logic [7:0] b, input bit lst, input t_row tag);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        pending_tags.push_back(tag);
        push        <= 1'b1;
        i_code_byte <= b;
        i_last_byte <= lst;
        items_sent++;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Push opcode, length and big-endian data with a bias toward extremes
    task automatic append_push(input int len);
        int sel;
        prog_bytes.push_back(BC_PUSH);
        prog_bytes.push_back(len[7:0]);
        repeat (len) begin
            sel = $urandom_range(0, 7);
            case (sel)
                0:       prog_bytes.push_back(8'h00);
                1:       prog_bytes.push_back(8'hFF);
                2:       prog_bytes.push_back(8'h80);
                default: prog_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic make_program(input t_prog_kind kind);
        int         depth;
        int         sel;
        int         cut;
        logic [7:0] b;
        depth = 0;
        case (kind)
            PROG_NOISE: begin
                repeat ($urandom_range(1, 12))
                    prog_bytes.push_back(8'($urandom_range(0, 255)));
            end
            PROG_DEEP: begin
                // Fill past the top so pushes get dropped, then work on a full stack
                repeat ($urandom_range(DEPTH + 1, DEPTH + 4))
                    append_push(($urandom_range(0, 3) == 0) ? 1 : 0);
                repeat ($urandom_range(1, 4))
                    prog_bytes.push_back($urandom_range(0, 1) ? BC_ADD : BC_MUL);
                prog_bytes.push_back(8'h00);
            end
            default: begin
                repeat ($urandom_range(1, 16)) begin
                    if (depth >= 2 && $urandom_range(0, 1) == 1) begin
                        prog_bytes.push_back($urandom_range(0, 1) ? BC_ADD : BC_MUL);
                        depth--;
                    end else if ($urandom_range(0, 9) == 0) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == BC_ADD || b == BC_MUL || b == BC_PUSH) b = 8'h00;
                        prog_bytes.push_back(b);
                    end else begin
                        sel = $urandom_range(0, 255);
                        if (sel == 0)       append_push(255);
                        else if (sel < 32)  append_push(0);
                        else if (sel < 64)  append_push($urandom_range(5, 12));
                        else                append_push($urandom_range(1, 4));
                        depth++;
                    end
                end
                if (depth == 0) append_push($urandom_range(0, 4));
                if (kind == PROG_CUT) begin
                    cut = $urandom_range(1, prog_bytes.size());
                    while (prog_bytes.size() > cut) void'(prog_bytes.pop_back());
                end
            end
        endcase
    endtask

    // Result side stalls: mode and duration drawn at random
    always @(posedge i_clk) begin
        if (pop_hold == 0) begin
            pop_mode = $urandom_range(0, 4);
            pop_hold = $urandom_range(20, 150);
        end else begin
            pop_hold--;
        end
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 3) != 0);
            2:       pop <= ($urandom_range(0, 3) == 0);
            3:       pop <= (pop_hold % 8 != 0);
            default: pop <= 1'b0;
        endcase
    end

    // Monitor: predict on accepted bytes, check accepted results
    always @(posedge i_clk) begin : monitor
        logic [31:0] pv;
        t_status     ps;
        t_row        tag;
        t_outcome    want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("FAILURE");
            $finish;
        end else begin
            if (i_rst_n && push && !full) begin
                tag = pending_tags.pop_front();
                if (evaluate_byte(i_code_byte, i_last_byte, pv, ps)) begin
                    if (tag.typed) begin
                        want.value  = tag.value;
                        want.status = tag.status;
                    end else begin
                        want.value  = pv;
                        want.status = ps;
                    end
                    expected_results.push_back(want);
                end
            end
            if (i_rst_n && pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", o_result_value, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_result_value !== want.value)
                        report_mismatch("result_value", o_result_value, want.value);
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_prog_kind kind;
        int         sel;
        int         programs;
        programs = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (DIRECTED_ROWS[r])
            send_item(DIRECTED_ROWS[r].code, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r]);

        // Random programs, one deep-stack program partway through
        while (items_sent < TOTAL_ITEMS) begin
            prog_bytes.delete();
            if (programs == 12) begin
                kind = PROG_DEEP;
            end else begin
                sel  = $urandom_range(0, 99);
                kind = (sel < 70) ? PROG_CLEAN : (sel < 85) ? PROG_CUT : PROG_NOISE;
            end
            make_program(kind);
            foreach (prog_bytes[k])
                send_item(prog_bytes[k], k == prog_bytes.size() - 1, NO_TAG);
            // Hold off until the block has drained everything
            if (kind == PROG_DEEP) begin
                push <= 1'b0;
                while (expected_results.size() != 0 || pending_tags.size() != 0)
                    @(posedge i_clk);
            end
            programs++;
        end

        // Drain and let any stray result show up
        push <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
